// File: hdl/u8dc_pkg.sv
// ----------------------------------------------------------------------------
// u8dc_pkg
// Shared types, constants and the code point classifier for the UTF-8
// decode/classify block.
// ----------------------------------------------------------------------------
package u8dc_pkg;

	localparam int BYTE_W  = 8;
	localparam int CP_W    = 21;
	localparam int CLASS_W = 2;
	localparam int LEFT_W  = 2;

	typedef logic [BYTE_W-1:0]  byte_t;
	typedef logic [CP_W-1:0]    cp_t;
	typedef logic [CLASS_W-1:0] class_t;
	typedef logic [LEFT_W-1:0]  left_t;

	// character classes
	localparam class_t CLASS_OTHER  = 2'd0;
	localparam class_t CLASS_DIGIT  = 2'd1;
	localparam class_t CLASS_LETTER = 2'd2;
	localparam class_t CLASS_CJK    = 2'd3;

	// continuation bytes still expected
	localparam left_t LEFT_NONE  = 2'd0;
	localparam left_t LEFT_ONE   = 2'd1;
	localparam left_t LEFT_TWO   = 2'd2;
	localparam left_t LEFT_THREE = 2'd3;

	// lead byte tags
	localparam byte_t LEAD2_MASK = 8'hE0;
	localparam byte_t LEAD2_TAG  = 8'hC0;
	localparam byte_t LEAD3_MASK = 8'hF0;
	localparam byte_t LEAD3_TAG  = 8'hE0;
	localparam byte_t LEAD4_MASK = 8'hF8;
	localparam byte_t LEAD4_TAG  = 8'hF0;
	localparam byte_t CONT_MASK  = 8'h3F;

	// CJK ranges
	localparam cp_t CJK_A_LO = 21'h04E00;
	localparam cp_t CJK_A_HI = 21'h09FFF;
	localparam cp_t CJK_B_LO = 21'h03400;
	localparam cp_t CJK_B_HI = 21'h04DBF;
	localparam cp_t CJK_C_LO = 21'h20000;
	localparam cp_t CJK_C_HI = 21'h2A6DF;

	function automatic class_t classify(input cp_t cp);
		class_t c;
		c = CLASS_OTHER;
		if (cp == '0) begin
			c = CLASS_CJK;
		end else if (cp >= 21'd48 && cp <= 21'd57) begin
			c = CLASS_DIGIT;
		end else if ((cp >= 21'd65 && cp <= 21'd90) || (cp >= 21'd97 && cp <= 21'd122)) begin
			c = CLASS_LETTER;
		end else if ((cp >= CJK_A_LO && cp <= CJK_A_HI) ||
				(cp >= CJK_B_LO && cp <= CJK_B_HI) ||
				(cp >= CJK_C_LO && cp <= CJK_C_HI)) begin
			c = CLASS_CJK;
		end
		return c;
	endfunction

endpackage

// File: hdl/utf8_decode_classify.sv
// Pipeline: an accepted byte loads the input register; its decode then loads
// the result register once that register is free (out_free).
// Throughput: one byte per cycle while out_ready is high; the result register
// frees in the same cycle it is taken, so both stages keep moving back to back.
// Reset (arst_n low, asynchronous): stages empty, no sequence open,
// partial code point cleared.
// ----------------------------------------------------------------------------
// utf8_decode_classify
// Streaming UTF-8 decoder. Each byte transfer may complete a code point,
// which leaves with a character class (other, digit, letter or CJK; null is CJK).
// ----------------------------------------------------------------------------
module utf8_decode_classify (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  u8dc_pkg::byte_t  in_byte,
	output logic             out_valid,
	input  logic             out_ready,
	output u8dc_pkg::cp_t    code_point,
	output u8dc_pkg::class_t char_class
);
	import u8dc_pkg::*;

	// input register
	logic  valid_s1;
	byte_t byte_s1;

	// result register
	logic   out_valid_q;
	cp_t    cp_q;
	class_t class_q;

	logic out_free;
	logic s1_move;
	logic dec_emit;
	cp_t  dec_cp;

	// result slot is free if empty or being taken this cycle
	assign out_free = !out_valid_q || out_ready;
	// byte in stage 1 is decoded (state advances) when the result slot is free
	assign s1_move  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || s1_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	u8dc_decoder u_dec (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (s1_move),
		.in_byte    (byte_s1),
		.emit       (dec_emit),
		.code_point (dec_cp)
	);

	// a byte that only extends an open sequence leaves the slot empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_move && dec_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && dec_emit) begin
			cp_q    <= dec_cp;
			class_q <= classify(dec_cp);
		end
	end

	assign out_valid  = out_valid_q;
	assign code_point = cp_q;
	assign char_class = class_q;

endmodule

// File: hdl/u8dc_decoder.sv
// ----------------------------------------------------------------------------
// u8dc_decoder
// Sequence state (bytes left, partial code point) and the per-byte decode.
// State advances on every byte that leaves the input register (step).
// ----------------------------------------------------------------------------
module u8dc_decoder (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  u8dc_pkg::byte_t in_byte,
	output logic            emit,
	output u8dc_pkg::cp_t   code_point
);
	import u8dc_pkg::*;

	left_t left_q, left_d;
	cp_t   accum_q, accum_d;
	cp_t   shifted;

	assign shifted = {accum_q[CP_W-7:0], in_byte[5:0] & CONT_MASK[5:0]};

	always_comb begin
		left_d     = left_q;
		accum_d    = accum_q;
		emit       = 1'b0;
		code_point = cp_t'(in_byte);
		if (left_q != LEFT_NONE) begin
			// tag bits of the continuation byte are not checked
			accum_d    = shifted;
			left_d     = left_q - LEFT_ONE;
			emit       = (left_q == LEFT_ONE);
			code_point = shifted;
		end else if ((in_byte & LEAD2_MASK) == LEAD2_TAG) begin
			accum_d = cp_t'(in_byte[4:0]);
			left_d  = LEFT_ONE;
		end else if ((in_byte & LEAD3_MASK) == LEAD3_TAG) begin
			accum_d = cp_t'(in_byte[3:0]);
			left_d  = LEFT_TWO;
		end else if ((in_byte & LEAD4_MASK) == LEAD4_TAG) begin
			accum_d = cp_t'(in_byte[2:0]);
			left_d  = LEFT_THREE;
		end else begin
			// ASCII or invalid lead goes out as is
			emit = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= LEFT_NONE;
			accum_q <= '0;
		end else if (step) begin
			left_q  <= left_d;
			accum_q <= accum_d;
		end
	end

endmodule
